FILE: rtl/kmcq_pkg.sv
package kmcq_pkg;

	localparam int PIX_AW   = 16;
	localparam int PIX_N    = 65536;
	localparam int CL_N     = 16;
	localparam int CL_W     = 4;
	localparam int CNT_W    = 17;
	localparam int SUM_W    = 24;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	localparam logic [1:0] REG_CLUSTERS = 2'd0;
	localparam logic [1:0] REG_ITERS    = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;
	localparam logic [1:0] REG_SEED     = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_STEP,
		ST_SEED_MOD,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_ASSIGN,
		ST_UPD_CLR,
		ST_UPD_ACC,
		ST_DIV,
		ST_DIV_WR
	} state_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		logic [31:0] r;
		r = {1'b0, v[31:1]};
		if (v[0]) begin
			r = r ^ LFSR_MASK;
		end
		return r;
	endfunction

endpackage

FILE: rtl/kmeans_color_quantizer.sv
// K-means color quantizer. Load and read items: one per cycle while busy is low; a read
// result is registered through rd_s1 and rd_s2 and strobes result_valid, the receiver cannot stall it.
// Last load: busy while seeding k centroids (LFSR step, modulo divide, pixel fetch, write),
// then per pass an assignment of every pixel, an accumulation, and per cluster three
// divides (none if empty) and a write; zero passes leave one assignment after the seeds.
// Reset: configuration to 8/10/3/seed 1, centroids zero, image empty; no memory reset.
module kmeans_color_quantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,
	input  logic        last_pixel,
	input  logic [15:0] pixel_index,
	output logic        result_valid,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic [3:0]  cluster_index
);
	localparam int AW = kmcq_pkg::PIX_AW;
	localparam int CW = kmcq_pkg::CL_W;

	// configuration
	logic [4:0]  clusters_q;
	logic [7:0]  iters_q;
	logic [2:0]  channels_q;
	logic [31:0] seed_q;
	logic [31:0] lfsr_q;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_comb begin
		case (reg_idx)
			kmcq_pkg::REG_CLUSTERS: prdata = {27'd0, clusters_q};
			kmcq_pkg::REG_ITERS:    prdata = {24'd0, iters_q};
			kmcq_pkg::REG_CHANNELS: prdata = {29'd0, channels_q};
			kmcq_pkg::REG_SEED:     prdata = seed_q;
			default:                prdata = '0;
		endcase
	end

	// memories
	logic [31:0]   pix_mem [kmcq_pkg::PIX_N];
	logic [CW-1:0] lab_mem [kmcq_pkg::PIX_N];
	logic [23:0]   cen_mem [kmcq_pkg::CL_N];
	logic [kmcq_pkg::CL_N-1:0] cen_vld_q;

	logic          pix_we;
	logic [AW-1:0] pix_wa;
	logic [31:0]   pix_wd;
	logic [AW-1:0] pix_ra;
	logic [31:0]   pix_rd_s1;
	logic          lab_we;
	logic [AW-1:0] lab_wa;
	logic [CW-1:0] lab_wd;
	logic [AW-1:0] lab_ra;
	logic [CW-1:0] lab_rd_s1;
	logic          cen_we;
	logic [CW-1:0] cen_wa;
	logic [23:0]   cen_wd;
	logic [CW-1:0] cen_ra;
	logic [23:0]   cen_raw_s1;
	logic          cen_vld_s1;
	logic [23:0]   cen_rd;

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_wa] <= pix_wd;
		pix_rd_s1 <= pix_mem[pix_ra];
		if (lab_we) lab_mem[lab_wa] <= lab_wd;
		lab_rd_s1 <= lab_mem[lab_ra];
		if (cen_we) cen_mem[cen_wa] <= cen_wd;
		cen_raw_s1 <= cen_mem[cen_ra];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_vld_q  <= '0;
			cen_vld_s1 <= 1'b0;
		end else begin
			if (cen_we) cen_vld_q[cen_wa] <= 1'b1;
			cen_vld_s1 <= cen_vld_q[cen_ra];
		end
	end
	assign cen_rd = cen_vld_s1 ? cen_raw_s1 : 24'd0;

	// per-cluster accumulators, small register files at fixed per-entry places
	logic [kmcq_pkg::SUM_W-1:0] sum_q [kmcq_pkg::CL_N][3];
	logic [kmcq_pkg::CNT_W-1:0] cnt_q [kmcq_pkg::CL_N];

	// control
	kmcq_pkg::state_t st_q, st_nx;
	logic [16:0]   total_q;
	logic          closed_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] c_q;
	logic [16:0]   p_q;
	logic [7:0]    it_q;
	logic          final_q;
	logic [1:0]    ch_q;
	logic          acc_vld_s1;
	logic          asg_vld_s1;
	logic [CW-1:0] asg_c_s1;
	logic [AW-1:0] asg_p_s1;
	logic          asg_last_s1;
	logic [31:0]   px_q;
	logic [17:0]   best_d_q;
	logic [CW-1:0] best_q;
	logic          rd_s1;
	logic          rd_ok_s1;
	logic          rd_s2;
	logic [7:0]    avg_q [3];

	logic load_acc, read_acc;
	assign load_acc = start && !busy && !req_type;
	assign read_acc = start && !busy && req_type;
	assign busy     = (st_q != kmcq_pkg::ST_IDLE);

	logic [4:0] k_eff;
	always_comb begin
		if (clusters_q == 5'd0) k_eff = 5'd1;
		else if (clusters_q > 5'd16) k_eff = 5'd16;
		else k_eff = clusters_q;
	end

	// divider for lfsr mod total and for the means
	logic        dv_start, dv_done;
	logic [31:0] dv_n, dv_q;
	logic [16:0] dv_d, dv_r;
	kmcq_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n), .divisor(dv_d),
		.done(dv_done), .quotient(dv_q), .remainder(dv_r)
	);

	// squared distance of the assign pipeline
	logic [17:0] sq_dist;
	always_comb begin
		logic signed [8:0] dr, dg, db;
		dr = $signed({1'b0, px_q[7:0]})   - $signed({1'b0, cen_rd[7:0]});
		dg = $signed({1'b0, px_q[15:8]})  - $signed({1'b0, cen_rd[15:8]});
		db = $signed({1'b0, px_q[23:16]}) - $signed({1'b0, cen_rd[23:16]});
		sq_dist = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
	end
	logic [17:0]   cand_d;
	logic [CW-1:0] cand_c;
	always_comb begin
		if (asg_c_s1 == '0 || sq_dist < best_d_q) begin
			cand_d = sq_dist;
			cand_c = asg_c_s1;
		end else begin
			cand_d = best_d_q;
			cand_c = best_q;
		end
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			kmcq_pkg::ST_IDLE:
				if (load_acc && last_pixel) begin
					if ((closed_q ? 17'd0 : total_q) != 17'd0
						|| (closed_q ? 17'd0 : total_q) < 17'(kmcq_pkg::PIX_N))
						st_nx = kmcq_pkg::ST_SEED_STEP;
				end
			kmcq_pkg::ST_SEED_STEP: st_nx = kmcq_pkg::ST_SEED_MOD;
			kmcq_pkg::ST_SEED_MOD:  if (dv_done) st_nx = kmcq_pkg::ST_SEED_RD;
			kmcq_pkg::ST_SEED_RD:   st_nx = kmcq_pkg::ST_SEED_WR;
			kmcq_pkg::ST_SEED_WR:
				if (c_q == k_q) st_nx = kmcq_pkg::ST_ASSIGN;
				else st_nx = kmcq_pkg::ST_SEED_STEP;
			kmcq_pkg::ST_ASSIGN:
				if (asg_vld_s1 && asg_last_s1 && asg_c_s1 == k_q
					&& 17'(asg_p_s1) + 17'd1 == total_q) begin
					if (final_q) st_nx = kmcq_pkg::ST_IDLE;
					else st_nx = kmcq_pkg::ST_UPD_CLR;
				end
			kmcq_pkg::ST_UPD_CLR: st_nx = kmcq_pkg::ST_UPD_ACC;
			kmcq_pkg::ST_UPD_ACC:
				if (!acc_vld_s1 && p_q == total_q) st_nx = kmcq_pkg::ST_DIV;
			kmcq_pkg::ST_DIV:
				if (cnt_q[c_q] == '0 || (dv_done && ch_q == 2'd2))
					st_nx = kmcq_pkg::ST_DIV_WR;
			kmcq_pkg::ST_DIV_WR:
				if (c_q == k_q) begin
					// the update of the last pass ends the run
					if (it_q == 8'd1) st_nx = kmcq_pkg::ST_IDLE;
					else st_nx = kmcq_pkg::ST_ASSIGN;
				end else st_nx = kmcq_pkg::ST_DIV;
			default: st_nx = kmcq_pkg::ST_IDLE;
		endcase
	end

	// datapath and outputs
	logic dv_run_q;
	logic div_kick;
	assign div_kick = (st_q == kmcq_pkg::ST_DIV) && !dv_run_q && cnt_q[c_q] != '0;
	always_comb begin
		dv_start = 1'b0;
		dv_n     = lfsr_q;
		dv_d     = total_q;
		if (st_q == kmcq_pkg::ST_SEED_STEP) begin
			dv_start = 1'b1;
			dv_n     = kmcq_pkg::lfsr_next(lfsr_q);
		end else if (div_kick) begin
			dv_start = 1'b1;
			dv_n     = 32'(sum_q[c_q][ch_q]);
			dv_d     = cnt_q[c_q];
		end
	end

	always_comb begin
		pix_we = load_acc && !(closed_q ? 1'b0 : total_q[16]);
		pix_wa = closed_q ? '0 : total_q[AW-1:0];
		pix_wd = {alpha_in, blue_in, green_in, red_in};
		pix_ra = read_acc ? pixel_index : p_q[AW-1:0];
		// seed pixel address holds until the centroid write samples the word
		if (st_q inside {kmcq_pkg::ST_SEED_MOD, kmcq_pkg::ST_SEED_RD}) pix_ra = dv_r[AW-1:0];
		lab_ra = read_acc ? pixel_index : p_q[AW-1:0];
		lab_we = asg_vld_s1 && asg_last_s1 && asg_c_s1 == k_q;
		lab_wa = asg_p_s1;
		lab_wd = cand_c;
		cen_we = (st_q == kmcq_pkg::ST_SEED_WR)
			|| (st_q == kmcq_pkg::ST_DIV_WR && cnt_q[c_q] != '0);
		cen_wa = c_q;
		cen_wd = (st_q == kmcq_pkg::ST_SEED_WR) ? pix_rd_s1[23:0]
			: {avg_q[2], avg_q[1], avg_q[0]};
		cen_ra = c_q;
		if (rd_s1) cen_ra = lab_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= kmcq_pkg::ST_IDLE;
			clusters_q <= 5'd8;
			iters_q    <= 8'd10;
			channels_q <= 3'd3;
			seed_q     <= 32'd1;
			lfsr_q     <= 32'd1;
			total_q    <= '0;
			closed_q   <= 1'b0;
			k_q        <= '0;
			c_q        <= '0;
			p_q        <= '0;
			it_q       <= '0;
			final_q    <= 1'b0;
			ch_q       <= '0;
			acc_vld_s1 <= 1'b0;
			asg_vld_s1 <= 1'b0;
			rd_s1      <= 1'b0;
			rd_s2      <= 1'b0;
			dv_run_q   <= 1'b0;
		end else begin
			st_q  <= st_nx;
			rd_s1 <= read_acc;
			rd_s2 <= rd_s1;
			if (cfg_wr) begin
				case (reg_idx)
					kmcq_pkg::REG_CLUSTERS: clusters_q <= pwdata[4:0];
					kmcq_pkg::REG_ITERS:    iters_q    <= pwdata[7:0];
					kmcq_pkg::REG_CHANNELS: channels_q <= pwdata[2:0];
					kmcq_pkg::REG_SEED: begin
						seed_q <= pwdata;
						lfsr_q <= (pwdata == '0) ? 32'd1 : pwdata;
					end
					default: ;
				endcase
			end
			if (load_acc) begin
				total_q  <= (closed_q ? 17'd0 : total_q) + {16'd0, !(closed_q ? 1'b0 : total_q[16])};
				closed_q <= last_pixel;
				if (last_pixel) begin
					k_q     <= CW'(k_eff - 5'd1);
					c_q     <= '0;
					it_q    <= iters_q;
					final_q <= (iters_q == 8'd0);
				end
			end
			case (st_q)
				kmcq_pkg::ST_SEED_STEP: lfsr_q <= kmcq_pkg::lfsr_next(lfsr_q);
				kmcq_pkg::ST_SEED_WR: begin
					c_q <= c_q + CW'(1);
					if (c_q == k_q) begin
						c_q <= '0;
						p_q <= '0;
					end
				end
				default: ;
			endcase
			// assign: pixel p over centroid c, one centroid read a cycle
			asg_vld_s1 <= 1'b0;
			if (st_q == kmcq_pkg::ST_ASSIGN && p_q < total_q) begin
				asg_vld_s1  <= 1'b1;
				asg_c_s1    <= c_q;
				asg_p_s1    <= p_q[AW-1:0];
				asg_last_s1 <= (c_q == k_q);
				if (c_q == k_q) begin
					c_q <= '0;
					p_q <= p_q + 17'd1;
				end else c_q <= c_q + CW'(1);
			end
			if (asg_vld_s1) begin
				best_d_q <= cand_d;
				best_q   <= cand_c;
			end
			if (st_q == kmcq_pkg::ST_ASSIGN && st_nx == kmcq_pkg::ST_UPD_CLR) begin
				p_q <= '0;
				c_q <= '0;
			end
			if (st_q == kmcq_pkg::ST_UPD_CLR) begin
				for (int i = 0; i < kmcq_pkg::CL_N; i++) begin
					cnt_q[i] <= '0;
					for (int j = 0; j < 3; j++) sum_q[i][j] <= '0;
				end
			end
			acc_vld_s1 <= (st_q == kmcq_pkg::ST_UPD_ACC) && p_q < total_q;
			if (st_q == kmcq_pkg::ST_UPD_ACC && p_q < total_q) p_q <= p_q + 17'd1;
			if (acc_vld_s1) begin
				cnt_q[lab_rd_s1] <= cnt_q[lab_rd_s1] + 17'd1;
				for (int j = 0; j < 3; j++)
					sum_q[lab_rd_s1][j] <= sum_q[lab_rd_s1][j]
						+ kmcq_pkg::SUM_W'(pix_rd_s1[8*j +: 8]);
			end
			if (st_q == kmcq_pkg::ST_UPD_ACC && st_nx == kmcq_pkg::ST_DIV) begin
				c_q  <= '0;
				ch_q <= '0;
			end
			if (dv_start) dv_run_q <= 1'b1;
			if (dv_done) begin
				dv_run_q <= 1'b0;
				if (st_q == kmcq_pkg::ST_DIV) begin
					avg_q[ch_q] <= dv_q[7:0];
					ch_q <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
				end
			end
			if (st_q == kmcq_pkg::ST_DIV_WR) begin
				ch_q <= '0;
				if (c_q == k_q) begin
					c_q  <= '0;
					p_q  <= '0;
					it_q <= it_q - 8'd1;
				end else c_q <= c_q + CW'(1);
			end
		end
	end

	// assign pixel fetch: hold pixel word for all centroids of that pixel
	logic [31:0] asg_px_s1;
	always_ff @(posedge clk) begin
		if (asg_vld_s1 && asg_c_s1 == '0) asg_px_s1 <= pix_rd_s1;
	end
	always_comb px_q = (asg_c_s1 == '0) ? pix_rd_s1 : asg_px_s1;

	// read path: label and pixel in s1, centroid in s2
	logic [7:0]    rd_alpha_s2;
	logic [CW-1:0] rd_lab_s2;
	logic          rd_ok_s2;
	always_ff @(posedge clk) begin
		rd_ok_s1    <= closed_q && {1'b0, pixel_index} < total_q;
		rd_ok_s2    <= rd_ok_s1;
		rd_lab_s2   <= lab_rd_s1;
		rd_alpha_s2 <= (channels_q == 3'd4) ? pix_rd_s1[31:24] : 8'd0;
	end
	assign result_valid  = rd_s2;
	assign red_out       = rd_ok_s2 ? cen_rd[7:0]   : 8'd0;
	assign green_out     = rd_ok_s2 ? cen_rd[15:8]  : 8'd0;
	assign blue_out      = rd_ok_s2 ? cen_rd[23:16] : 8'd0;
	assign alpha_out     = rd_ok_s2 ? rd_alpha_s2   : 8'd0;
	assign cluster_index = rd_ok_s2 ? rd_lab_s2     : '0;

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !rd_s1 |-> ##1 !result_valid) else $error("result while clustering");
	a_rd_follow: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |-> ##2 result_valid) else $error("read result lost");
	a_cen_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cen_we) else $error("centroid write while idle");
endmodule

FILE: rtl/kmcq_divider.sv
// Restoring divider, one quotient bit per cycle.
module kmcq_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [31:0]                  dividend,
	input  logic [kmcq_pkg::CNT_W-1:0]   divisor,
	output logic                         done,
	output logic [31:0]                  quotient,
	output logic [kmcq_pkg::CNT_W-1:0]   remainder
);
	logic [5:0]                     cnt_q;
	logic                           run_q;
	logic [31:0]                    quo_q;
	logic [kmcq_pkg::CNT_W:0]       rem_q;
	logic [kmcq_pkg::CNT_W-1:0]     div_q;
	logic [kmcq_pkg::CNT_W:0]       trial;

	assign trial = {rem_q[kmcq_pkg::CNT_W-1:0], quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[kmcq_pkg::CNT_W-1:0];
endmodule
